// ----- hw/rtl/ltsm_pkg.sv -----
// Shared types and constants for the loop timing statistics monitor.
`default_nettype none
package ltsm_pkg;

	localparam int TIME_W = 63;
	localparam int DUR_W  = 32;
	localparam int CNT_W  = 64;
	localparam int ALU_W  = 64;
	localparam int Q_W    = 27;
	localparam int RATE_W = 17;
	localparam int FILLO_W = 10;

	// Event codes carried on the action field.
	localparam logic [2:0] ACT_START = 3'd0;
	localparam logic [2:0] ACT_END   = 3'd1;
	localparam logic [2:0] ACT_MISS  = 3'd2;
	localparam logic [2:0] ACT_RESET = 3'd3;
	localparam logic [2:0] ACT_QUERY = 3'd4;

	localparam logic [DUR_W-1:0]  TARGET_RESET = 32'd10000;
	// 100000000 as a 27-bit multiplier, walked from bit 26 down.
	localparam logic [Q_W-1:0]    RATE_SCALE   = 27'd100000000;
	localparam logic [4:0]        SCALE_MSB    = 5'd26;
	localparam logic [RATE_W-1:0] RATE_CAP     = 17'd100000;

	// One event presented to the statistics registers.
	typedef struct packed {
		logic              apply;
		logic [2:0]        action;
		logic [TIME_W-1:0] now;
		logic [DUR_W-1:0]  dur;
		logic              period_ok;
		logic [DUR_W-1:0]  period;
	} evt_t;

	// Current statistics as seen by the sequencer and the result register.
	typedef struct packed {
		logic [DUR_W-1:0]   target;
		logic [DUR_W-1:0]   last_dur;
		logic [DUR_W-1:0]   worst_dur;
		logic [FILLO_W-1:0] fill;
		logic [CNT_W-1:0]   total_count;
		logic [DUR_W-1:0]   misses;
		logic [TIME_W-1:0]  prev_start;
		logic [DUR_W-1:0]   period_sum;
		logic [DUR_W-1:0]   period_peak;
		logic [DUR_W-1:0]   period_count;
		logic [TIME_W-1:0]  window_start_time;
		logic [CNT_W-1:0]   window_start_count;
		logic [DUR_W-1:0]   window_count;
	} stats_t;

endpackage
`default_nettype wire

// ----- hw/rtl/loop_timing_statistics_monitor_unit.sv -----
// Top level of the loop timing statistics monitor: sequencer, shared unit, result register.
`default_nettype none
// Loop timing statistics monitor. Each input transaction carries one event
// (loop start, loop end, deadline miss, report-window reset or query) and
// yields exactly one output transaction with every statistic taken after the
// event's update. The block handles one transaction at a time: in_stall is
// high from the accept edge until the result is placed in the output
// register, and a held result does not block the next input transaction.
// The period, window, rate and average arithmetic runs through one 64-bit
// add/subtract unit under a small sequencer, whose steps are the accept, the
// period difference and event update, window length, loop count, average setup
// and result load; when a rate is due, the overflow check and the rate (27
// compare steps over the bits of the 100000000 scale plus an add and a compare
// for each of its 12 set bits); and 32 restoring-division steps for the
// average period when any period was counted.
// target_period_us is to be written through cfg_wr_en/cfg_wr_data only while
// the block is idle; the block itself does not enforce this. It resets to
// 10000. Reset needs no clearing pass.
module loop_timing_statistics_monitor_unit #(
	parameter int WINDOW_DEPTH = 1000
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [62:0] time_us,
	input  wire logic [31:0] duration_us,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      last_duration,
	output logic [31:0]      worst_duration,
	output logic [9:0]       fill_count,
	output logic [63:0]      total_loops,
	output logic [31:0]      miss_count,
	output logic [31:0]      remaining_us,
	output logic [16:0]      rate_centi_hz,
	output logic [31:0]      window_loops,
	output logic [31:0]      period_avg_us,
	output logic [31:0]      period_max_us
);

	localparam int AW = ltsm_pkg::ALU_W;

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EVT   = 4'd1;  // period difference
	localparam logic [3:0] S_APPLY = 4'd2;  // commit event to statistics
	localparam logic [3:0] S_RLEN  = 4'd3;  // window length in time
	localparam logic [3:0] S_RCNT  = 4'd4;  // loops since window opened
	localparam logic [3:0] S_RCHK  = 4'd5;  // loops >= length: cap
	localparam logic [3:0] S_RDBL  = 4'd6;  // double remainder, compare
	localparam logic [3:0] S_RADD  = 4'd7;  // add loop count
	localparam logic [3:0] S_RCMP  = 4'd8;  // compare after add
	localparam logic [3:0] S_AVG   = 4'd9;  // set up average division
	localparam logic [3:0] S_DIV   = 4'd10; // one quotient bit per cycle
	localparam logic [3:0] S_DONE  = 4'd11; // load result register

	logic [3:0]  state_q;
	logic [2:0]  act_q;
	logic [62:0] now_q;
	logic [31:0] dur_q;
	logic        pok_q;
	logic [31:0] period_q;
	logic [62:0] u_q;     // window length in microseconds
	logic        ugt_q;   // timestamp is after window start
	logic [63:0] c_q;     // loops since window opened
	logic [63:0] r_q;     // running remainder (rate and average)
	logic [26:0] q_q;     // rate quotient
	logic [4:0]  bit_q;   // scale bit or division step
	logic [16:0] rate_q;
	logic [31:0] dq_q;    // dividend shifting out, quotient shifting in

	logic        out_valid_q;
	logic [31:0] o_last_q, o_worst_q, o_miss_q, o_rem_q, o_wloops_q, o_avg_q, o_pmax_q;
	logic [9:0]  o_fill_q;
	logic [63:0] o_total_q;
	logic [16:0] o_rate_q;

	logic [AW-1:0] alu_a, alu_b, alu_sum;
	logic          alu_sub, alu_carry;
	logic          sum_nz;
	logic [63:0]   dbl;
	logic [32:0]   div_x;
	logic          rate_due;
	logic          in_acc;
	logic          out_load;

	ltsm_pkg::evt_t   evt;
	ltsm_pkg::stats_t st;

	ltsm_alu u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.sub   (alu_sub),
		.sum   (alu_sum),
		.carry (alu_carry)
	);

	ltsm_stats #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_stats (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.evt         (evt),
		.st          (st)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign sum_nz   = (alu_sum != '0);
	// remainder stays below the window length, so the top bit drops out
	assign dbl      = {r_q[62:0], 1'b0};
	assign div_x    = {r_q[31:0], dq_q[31]};
	assign rate_due = (st.window_count != '0) && sum_nz && ugt_q;

	always_comb begin
		evt.apply     = (state_q == S_APPLY);
		evt.action    = act_q;
		evt.now       = now_q;
		evt.dur       = dur_q;
		evt.period_ok = pok_q;
		evt.period    = period_q;
	end

	// Steer the shared unit for the current step.
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b1;
		unique case (state_q)
			S_EVT: begin
				alu_a = {1'b0, now_q};
				alu_b = {1'b0, st.prev_start};
			end
			S_RLEN: begin
				alu_a = {1'b0, now_q};
				alu_b = {1'b0, st.window_start_time};
			end
			S_RCNT: begin
				alu_a = st.total_count;
				alu_b = st.window_start_count;
			end
			S_RCHK: begin
				alu_a = c_q;
				alu_b = {1'b0, u_q};
			end
			S_RDBL: begin
				alu_a = dbl;
				alu_b = {1'b0, u_q};
			end
			S_RADD: begin
				alu_a   = r_q;
				alu_b   = c_q;
				alu_sub = 1'b0;
			end
			S_RCMP: begin
				alu_a = r_q;
				alu_b = {1'b0, u_q};
			end
			S_DIV: begin
				alu_a = AW'(div_x);
				alu_b = AW'(st.period_count);
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_EVT;
					end
				end
				S_EVT:   state_q <= S_APPLY;
				S_APPLY: state_q <= S_RLEN;
				S_RLEN:  state_q <= S_RCNT;
				S_RCNT:  state_q <= rate_due ? S_RCHK : S_AVG;
				S_RCHK:  state_q <= alu_carry ? S_AVG : S_RDBL;
				S_RDBL: begin
					if (ltsm_pkg::RATE_SCALE[bit_q]) begin
						state_q <= S_RADD;
					end else if (bit_q == '0) begin
						state_q <= S_AVG;
					end
				end
				S_RADD: state_q <= S_RCMP;
				S_RCMP: state_q <= (bit_q == '0) ? S_AVG : S_RDBL;
				S_AVG:  state_q <= (st.period_count == '0) ? S_DONE : S_DIV;
				S_DIV: begin
					if (bit_q == '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q <= action;
			now_q <= time_us;
			dur_q <= duration_us;
		end
		case (state_q)
			S_EVT: begin
				// a period counts only after a nonzero start and a strictly later time
				pok_q    <= (st.prev_start != '0) && alu_carry && sum_nz;
				period_q <= alu_sum[31:0];
			end
			S_RLEN: begin
				u_q    <= alu_sum[62:0];
				ugt_q  <= alu_carry && sum_nz;
				rate_q <= '0;
			end
			S_RCNT: begin
				c_q <= alu_sum;
			end
			S_RCHK: begin
				if (alu_carry) begin
					rate_q <= ltsm_pkg::RATE_CAP;
				end
				r_q   <= '0;
				q_q   <= '0;
				bit_q <= ltsm_pkg::SCALE_MSB;
			end
			S_RDBL: begin
				if (alu_carry) begin
					r_q <= alu_sum;
					q_q <= {q_q[25:0], 1'b1};
				end else begin
					r_q <= dbl;
					q_q <= {q_q[25:0], 1'b0};
				end
				if (!ltsm_pkg::RATE_SCALE[bit_q]) begin
					if (bit_q == '0) begin
						rate_q <= ({q_q[25:0], alu_carry} > 27'(ltsm_pkg::RATE_CAP))
							? ltsm_pkg::RATE_CAP : {q_q[15:0], alu_carry};
					end else begin
						bit_q <= bit_q - 5'd1;
					end
				end
			end
			S_RADD: begin
				r_q <= alu_sum;
			end
			S_RCMP: begin
				if (alu_carry) begin
					r_q <= alu_sum;
					q_q <= q_q + 27'd1;
				end
				if (bit_q == '0) begin
					rate_q <= ((q_q + 27'(alu_carry)) > 27'(ltsm_pkg::RATE_CAP))
						? ltsm_pkg::RATE_CAP : 17'(q_q + 27'(alu_carry));
				end else begin
					bit_q <= bit_q - 5'd1;
				end
			end
			S_AVG: begin
				r_q   <= '0;
				dq_q  <= (st.period_count == '0) ? '0 : st.period_sum;
				bit_q <= 5'd31;
			end
			S_DIV: begin
				r_q   <= {32'd0, (alu_carry ? alu_sum[31:0] : div_x[31:0])};
				dq_q  <= {dq_q[30:0], alu_carry};
				bit_q <= bit_q - 5'd1;
			end
			default: begin
				// hold
			end
		endcase
	end

	// Output register: holds a result until taken, frees the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_last_q   <= st.last_dur;
			o_worst_q  <= st.worst_dur;
			o_fill_q   <= st.fill;
			o_total_q  <= st.total_count;
			o_miss_q   <= st.misses;
			o_rem_q    <= (st.last_dur < st.target) ? (st.target - st.last_dur) : '0;
			o_rate_q   <= rate_q;
			o_wloops_q <= st.window_count;
			o_avg_q    <= dq_q;
			o_pmax_q   <= st.period_peak;
		end
	end

	assign out_valid      = out_valid_q;
	assign last_duration  = o_last_q;
	assign worst_duration = o_worst_q;
	assign fill_count     = o_fill_q;
	assign total_loops    = o_total_q;
	assign miss_count     = o_miss_q;
	assign remaining_us   = o_rem_q;
	assign rate_centi_hz  = o_rate_q;
	assign window_loops   = o_wloops_q;
	assign period_avg_us  = o_avg_q;
	assign period_max_us  = o_pmax_q;

`ifndef SYNTHESIS
	a_accept_starts_event: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_EVT))
		else $error("accepted transaction did not start the event step");

	a_rate_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDBL) |-> (r_q < {1'b0, u_q}))
		else $error("rate remainder not below window length");

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (r_q < AW'(st.period_count)))
		else $error("division remainder not below divisor");

	a_rate_capped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (o_rate_q <= ltsm_pkg::RATE_CAP))
		else $error("rate above cap");

	a_load_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (!in_stall && out_valid_q))
		else $error("result load did not free the input side");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/ltsm_alu.sv -----
// Shared 64-bit add/subtract unit with carry out (carry set means no borrow).
`default_nettype none
module ltsm_alu (
	input  wire logic [ltsm_pkg::ALU_W-1:0] a,
	input  wire logic [ltsm_pkg::ALU_W-1:0] b,
	input  wire logic                       sub,
	output logic      [ltsm_pkg::ALU_W-1:0] sum,
	output logic                            carry
);

	logic [ltsm_pkg::ALU_W-1:0] b_op;

	assign b_op = sub ? ~b : b;
	assign {carry, sum} = {1'b0, a} + {1'b0, b_op} + {{ltsm_pkg::ALU_W{1'b0}}, sub};

endmodule
`default_nettype wire

// ----- hw/rtl/ltsm_stats.sv -----
// Statistics registers of the loop timing monitor and their per-event update.
`default_nettype none
module ltsm_stats #(
	parameter int WINDOW_DEPTH = 1000
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [ltsm_pkg::DUR_W-1:0]    cfg_wr_data,
	input  wire ltsm_pkg::evt_t                evt,
	output ltsm_pkg::stats_t                   st
);

	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

	logic [FILL_W-1:0]               fill_q;
	logic [ltsm_pkg::DUR_W-1:0]      target_q;
	logic [ltsm_pkg::DUR_W-1:0]      last_dur_q;
	logic [ltsm_pkg::DUR_W-1:0]      worst_dur_q;
	logic [ltsm_pkg::CNT_W-1:0]      total_q;
	logic [ltsm_pkg::DUR_W-1:0]      misses_q;
	logic [ltsm_pkg::TIME_W-1:0]     prev_start_q;
	logic [ltsm_pkg::DUR_W-1:0]      psum_q;
	logic [ltsm_pkg::DUR_W-1:0]      ppeak_q;
	logic [ltsm_pkg::DUR_W-1:0]      pcount_q;
	logic [ltsm_pkg::TIME_W-1:0]     wst_q;
	logic [ltsm_pkg::CNT_W-1:0]      wsc_q;
	logic [ltsm_pkg::DUR_W-1:0]      wcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= ltsm_pkg::TARGET_RESET;
			fill_q       <= '0;
			last_dur_q   <= '0;
			worst_dur_q  <= '0;
			total_q      <= '0;
			misses_q     <= '0;
			prev_start_q <= '0;
			psum_q       <= '0;
			ppeak_q      <= '0;
			pcount_q     <= '0;
			wst_q        <= '0;
			wsc_q        <= '0;
			wcount_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				target_q <= cfg_wr_data;
			end
			if (evt.apply) begin
				unique case (evt.action)
					ltsm_pkg::ACT_START: begin
						if (evt.period_ok) begin
							psum_q   <= psum_q + evt.period;
							pcount_q <= pcount_q + 32'd1;
							if (evt.period > ppeak_q) begin
								ppeak_q <= evt.period;
							end
						end
						prev_start_q <= evt.now;
					end
					ltsm_pkg::ACT_END: begin
						if (fill_q < FILL_W'(WINDOW_DEPTH)) begin
							fill_q <= fill_q + FILL_W'(1);
						end
						last_dur_q <= evt.dur;
						if (evt.dur > worst_dur_q) begin
							worst_dur_q <= evt.dur;
						end
						total_q  <= total_q + 64'd1;
						wcount_q <= wcount_q + 32'd1;
					end
					ltsm_pkg::ACT_MISS: begin
						misses_q <= misses_q + 32'd1;
					end
					ltsm_pkg::ACT_RESET: begin
						wst_q    <= evt.now;
						wsc_q    <= total_q;
						wcount_q <= '0;
						psum_q   <= '0;
						ppeak_q  <= '0;
						pcount_q <= '0;
					end
					default: begin
						// query and unused codes: hold everything
					end
				endcase
			end
		end
	end

	always_comb begin
		st.target             = target_q;
		st.last_dur           = last_dur_q;
		st.worst_dur          = worst_dur_q;
		st.fill               = ltsm_pkg::FILLO_W'(fill_q);
		st.total_count        = total_q;
		st.misses             = misses_q;
		st.prev_start         = prev_start_q;
		st.period_sum         = psum_q;
		st.period_peak        = ppeak_q;
		st.period_count       = pcount_q;
		st.window_start_time  = wst_q;
		st.window_start_count = wsc_q;
		st.window_count       = wcount_q;
	end

endmodule
`default_nettype wire

// ----- tb/sv/loop_timing_statistics_monitor_unit_tb.sv -----
// Self-checking testbench for the loop timing statistics monitor, with a built-in predictor.
`default_nettype none
module loop_timing_statistics_monitor_unit_tb;

	// Action codes past query: the block must treat them as a plain query.
	localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
	localparam logic [2:0] ACT_SPARE_MID = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI  = 3'd7;

	localparam int FILL_DEPTH   = 1000;
	localparam int NUM_DIRECTED = 25;
	localparam int RANDOM_ITEMS = 80;    // per target setting, four settings
	localparam int FILL_ITEMS   = 50;    // closing run of loop ends in a fresh window
	localparam int SETTLE_WAIT  = 4;
	localparam int DRAIN_WAIT   = 120;   // longer than the slowest transaction
	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	// Every statistic carried by one output transaction.
	typedef struct packed {
		logic [31:0] last;
		logic [31:0] worst;
		logic [9:0]  fill;
		logic [63:0] total;
		logic [31:0] misses;
		logic [31:0] remaining;
		logic [16:0] rate;
		logic [31:0] window;
		logic [31:0] avg;
		logic [31:0] peak;
	} loop_stats_t;

	// One row of the directed table; typed rows carry a hand-written expectation.
	typedef struct packed {
		logic [2:0]  act;
		logic [62:0] stamp;
		logic [31:0] dur;
		logic        typed;
		loop_stats_t want;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  action = ltsm_pkg::ACT_QUERY;
	logic [62:0] time_us = '0;
	logic [31:0] duration_us = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] last_duration;
	logic [31:0] worst_duration;
	logic [9:0]  fill_count;
	logic [63:0] total_loops;
	logic [31:0] miss_count;
	logic [31:0] remaining_us;
	logic [16:0] rate_centi_hz;
	logic [31:0] window_loops;
	logic [31:0] period_avg_us;
	logic [31:0] period_max_us;

	loop_timing_statistics_monitor_unit #(
		.WINDOW_DEPTH(FILL_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.time_us(time_us),
		.duration_us(duration_us),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.last_duration(last_duration),
		.worst_duration(worst_duration),
		.fill_count(fill_count),
		.total_loops(total_loops),
		.miss_count(miss_count),
		.remaining_us(remaining_us),
		.rate_centi_hz(rate_centi_hz),
		.window_loops(window_loops),
		.period_avg_us(period_avg_us),
		.period_max_us(period_max_us)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Statistics we expect the block to hold, updated at every accepted transaction.
	logic [31:0] cur_target;
	logic [31:0] cur_last;
	logic [31:0] cur_worst;
	int          cur_fill;
	logic [63:0] cur_total;
	logic [31:0] cur_misses;
	logic [62:0] cur_prev_start;
	logic [31:0] cur_psum;
	logic [31:0] cur_ppeak;
	logic [31:0] cur_pcount;
	logic [62:0] win_time;
	logic [63:0] win_base;
	logic [31:0] win_loops;

	loop_stats_t pending_stats [$];   // expected output transactions, oldest first
	int          mismatches = 0;
	int unsigned cycle_count = 0;
	logic [62:0] clock_us;            // running timestamp of the well-formed loop traffic
	bit          calm_in = 1'b0;
	bit          calm_out = 1'b0;
	int          stall_hold = 0;
	directed_row_t directed_rows [NUM_DIRECTED];

	// Apply one event to the expected statistics and return the resulting snapshot.
	function automatic loop_stats_t predict_stats(input logic [2:0] act, input logic [62:0] now,
			input logic [31:0] dur);
		loop_stats_t  r;
		logic [62:0]  delta;
		logic [62:0]  span;
		logic [63:0]  loops;
		logic [127:0] scaled;
		case (act)
			ltsm_pkg::ACT_START: begin
				// Measure a period only against an earlier nonzero start that lies behind us.
				if (cur_prev_start != '0 && now > cur_prev_start) begin
					delta = now - cur_prev_start;
					cur_psum = cur_psum + delta[31:0];
					if (delta[31:0] > cur_ppeak)
						cur_ppeak = delta[31:0];
					cur_pcount = cur_pcount + 32'd1;
				end
				cur_prev_start = now;
			end
			ltsm_pkg::ACT_END: begin
				if (cur_fill < FILL_DEPTH)
					cur_fill++;
				cur_last = dur;
				if (dur > cur_worst)
					cur_worst = dur;
				cur_total = cur_total + 64'd1;
				win_loops = win_loops + 32'd1;
			end
			ltsm_pkg::ACT_MISS: cur_misses = cur_misses + 32'd1;
			ltsm_pkg::ACT_RESET: begin
				win_time = now;
				win_base = cur_total;
				win_loops = '0;
				cur_psum = '0;
				cur_ppeak = '0;
				cur_pcount = '0;
			end
			default: ;
		endcase
		r.last = cur_last;
		r.worst = cur_worst;
		r.fill = cur_fill[9:0];
		r.total = cur_total;
		r.misses = cur_misses;
		r.remaining = (cur_last < cur_target) ? cur_target - cur_last : '0;
		r.window = win_loops;
		r.avg = (cur_pcount != '0) ? cur_psum / cur_pcount : '0;
		r.peak = cur_ppeak;
		// Rate over the report window: exact wide quotient, then cap.
		r.rate = '0;
		loops = cur_total - win_base;
		if (win_loops != '0 && loops != '0 && now > win_time) begin
			span = now - win_time;
			scaled = ({64'd0, loops} * 128'd100000000) / {65'd0, span};
			r.rate = (scaled > 128'(ltsm_pkg::RATE_CAP)) ? ltsm_pkg::RATE_CAP : scaled[16:0];
		end
		return r;
	endfunction

	function automatic loop_stats_t stats_of(input logic [31:0] last, worst,
			input logic [9:0] fill, input logic [63:0] total, input logic [31:0] misses,
			remaining, input logic [16:0] rate, input logic [31:0] window, avg, peak);
		loop_stats_t r;
		r.last = last;
		r.worst = worst;
		r.fill = fill;
		r.total = total;
		r.misses = misses;
		r.remaining = remaining;
		r.rate = rate;
		r.window = window;
		r.avg = avg;
		r.peak = peak;
		return r;
	endfunction

	function automatic logic [62:0] rand_stamp();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[62:0];
	endfunction

	// Sender gap: mostly none or short, a few long, and calm stretches with none at all.
	function automatic int pick_gap();
		int r;
		if ($urandom_range(0, 29) == 0)
			calm_in = !calm_in;
		r = $urandom_range(0, 99);
		if (calm_in || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// Processing time of a finished loop, clustered around the target with some outliers.
	function automatic logic [31:0] pick_duration();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return cur_target - 32'($urandom_range(0, 2000));
		if (r < 90)
			return cur_target + 32'($urandom_range(0, 2000));
		return $urandom;
	endfunction

	// Start-to-start spacing: nominal 100 Hz, some repeats and some large jumps.
	function automatic logic [62:0] pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return 63'($urandom_range(9000, 11000));
		if (r < 93)
			return '0;
		return 63'($urandom);
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected %0h, got %0h", what, want, got);
	endtask

	task automatic compare_field(input string what, input logic [63:0] want, input logic [63:0] got);
		if (want !== got)
			flag_mismatch(what, want, got);
	endtask

	// Present one event, hold it until accepted, record what must come back, then maybe idle.
	// With no gap, in_valid stays high and the caller drives the next transaction
	// in this same time step.
	task automatic send_event(input logic [2:0] act, input logic [62:0] stamp,
			input logic [31:0] dur, input bit use_given, input loop_stats_t given);
		loop_stats_t predicted;
		int gap;
		in_valid <= 1'b1;
		action <= act;
		time_us <= stamp;
		duration_us <= dur;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = predict_stats(act, stamp, dur);
		pending_stats.push_back(use_given ? given : predicted);
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every outstanding result has been taken.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_target(input logic [31:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cur_target = value;
		cfg_wr_en <= 1'b0;
	endtask

	// Mostly well-formed loop cycles (start, maybe miss, end, maybe query or window reset)
	// with random content; the rest is noise over every action code and the full timestamp.
	task automatic loop_traffic(input int count);
		int          sent;
		logic [2:0]  act;
		logic [62:0] stamp;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 80) begin
				send_event(ltsm_pkg::ACT_START, clock_us, $urandom, 1'b0, '0);
				sent++;
				if ($urandom_range(0, 9) == 0) begin
					send_event(ltsm_pkg::ACT_MISS, clock_us + 63'($urandom_range(0, 5000)),
						$urandom, 1'b0, '0);
					sent++;
				end
				if ($urandom_range(0, 19) != 0) begin
					send_event(ltsm_pkg::ACT_END, clock_us + 63'($urandom_range(100, 9000)),
						pick_duration(), 1'b0, '0);
					sent++;
				end
				if ($urandom_range(0, 4) == 0) begin
					send_event(ltsm_pkg::ACT_QUERY, clock_us + 63'($urandom_range(0, 9000)),
						$urandom, 1'b0, '0);
					sent++;
				end
				if ($urandom_range(0, 24) == 0) begin
					send_event(ltsm_pkg::ACT_RESET, clock_us + 63'($urandom_range(0, 9000)),
						$urandom, 1'b0, '0);
					sent++;
				end
				clock_us = clock_us + pick_period();
			end else begin
				act = 3'($urandom_range(0, 7));
				if ($urandom_range(0, 3) == 0)
					stamp = rand_stamp();
				else
					stamp = clock_us + 63'($urandom_range(0, 20000)) - 63'd10000;
				// Follow a wild start so later loop cycles keep measuring periods.
				if (act == ltsm_pkg::ACT_START)
					clock_us = stamp;
				send_event(act, stamp, $urandom, 1'b0, '0);
				sent++;
			end
		end
	endtask

	// Random backpressure on the result side: short holds, a few long ones,
	// and calm stretches with no stall.
	always @(posedge clk) begin : result_backpressure
		int r;
		if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			if ($urandom_range(0, 39) == 0)
				calm_out <= !calm_out;
			r = $urandom_range(0, 99);
			if (calm_out) begin
				out_stall <= 1'b0;
				stall_hold <= $urandom_range(20, 200);
			end else if (r < 50) begin
				out_stall <= 1'b0;
				stall_hold <= $urandom_range(0, 7);
			end else if (r < 90) begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(0, 3);
			end else begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(10, 60);
			end
		end
	end

	// Check each accepted result against the oldest expectation, field by field.
	always @(posedge clk) begin : result_check
		loop_stats_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_stats.size() == 0) begin
				flag_mismatch("result with no transaction outstanding", '0, '1);
			end else begin
				want = pending_stats.pop_front();
				compare_field("last_duration", want.last, last_duration);
				compare_field("worst_duration", want.worst, worst_duration);
				compare_field("fill_count", want.fill, fill_count);
				compare_field("total_loops", want.total, total_loops);
				compare_field("miss_count", want.misses, miss_count);
				compare_field("remaining_us", want.remaining, remaining_us);
				compare_field("rate_centi_hz", want.rate, rate_centi_hz);
				compare_field("window_loops", want.window, window_loops);
				compare_field("period_avg_us", want.avg, period_avg_us);
				compare_field("period_max_us", want.peak, period_max_us);
			end
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("loop_timing_statistics_monitor_unit: mismatch");
			$finish;
		end
	end

	initial begin
		loop_stats_t after_reset;
		loop_stats_t after_miss;
		logic [31:0] odd_target;
		after_reset = stats_of(0, 0, 0, 0, 0, 10000, 0, 0, 0, 0);
		after_miss = stats_of(0, 0, 0, 0, 1, 10000, 0, 0, 0, 0);

		// Mirror the reset state of the block.
		cur_target = ltsm_pkg::TARGET_RESET;
		cur_last = '0;
		cur_worst = '0;
		cur_fill = 0;
		cur_total = '0;
		cur_misses = '0;
		cur_prev_start = '0;
		cur_psum = '0;
		cur_ppeak = '0;
		cur_pcount = '0;
		win_time = '0;
		win_base = '0;
		win_loops = '0;
		clock_us = 63'd50000;

		directed_rows = '{
			// fresh after reset, then unknown codes with every input bit toggled
			'{ltsm_pkg::ACT_QUERY, 63'd0, 32'd0, 1'b1, after_reset},
			'{ACT_SPARE_HI, '1, '1, 1'b1, after_reset},
			'{ACT_SPARE_LO, 63'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b1, after_reset},
			'{ACT_SPARE_MID, 63'h2AAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b1, after_reset},
			'{ltsm_pkg::ACT_MISS, 63'd0, 32'd0, 1'b1, after_miss},
			// duration extremes; no rate while the timestamp sits at the window start
			'{ltsm_pkg::ACT_END, 63'd0, 32'hFFFF_FFFF, 1'b1,
				stats_of('1, '1, 1, 1, 1, 0, 0, 1, 0, 0)},
			'{ltsm_pkg::ACT_END, 63'd0, 32'd0, 1'b1,
				stats_of(0, '1, 2, 2, 1, 10000, 0, 2, 0, 0)},
			// two loops in one microsecond: rate overflows and caps
			'{ltsm_pkg::ACT_QUERY, 63'd1, 32'd0, 1'b1,
				stats_of(0, '1, 2, 2, 1, 10000, 100000, 2, 0, 0)},
			// no earlier start, a first period, repeated and going-back timestamps
			'{ltsm_pkg::ACT_START, 63'd0, 32'd0, 1'b0, '0},
			'{ltsm_pkg::ACT_START, 63'd1000, 32'd0, 1'b0, '0},
			'{ltsm_pkg::ACT_START, 63'd11000, 32'd0, 1'b0, '0},
			'{ltsm_pkg::ACT_START, 63'd11000, 32'd0, 1'b0, '0},
			'{ltsm_pkg::ACT_START, 63'd5000, 32'd0, 1'b0, '0},
			// period wider than 32 bits keeps only its low word
			'{ltsm_pkg::ACT_START, 63'h0000_0001_0000_138F, 32'd0, 1'b0, '0},
			'{ltsm_pkg::ACT_START, '1, 32'd0, 1'b0, '0},
			// window reset, then queries at and before the window start
			'{ltsm_pkg::ACT_RESET, 63'd20000, 32'd0, 1'b0, '0},
			'{ltsm_pkg::ACT_QUERY, 63'd20000, 32'd0, 1'b0, '0},
			'{ltsm_pkg::ACT_QUERY, 63'd10000, 32'd0, 1'b0, '0},
			'{ltsm_pkg::ACT_END, 63'd20500, 32'd12345, 1'b0, '0},
			'{ltsm_pkg::ACT_QUERY, 63'd2020000, 32'd0, 1'b0, '0},
			'{ltsm_pkg::ACT_QUERY, '1, 32'd0, 1'b0, '0},
			// window opened at the last timestamp: nothing can come after it
			'{ltsm_pkg::ACT_RESET, '1, 32'd0, 1'b0, '0},
			'{ltsm_pkg::ACT_END, '1, 32'd9999, 1'b0, '0},
			'{ltsm_pkg::ACT_QUERY, '1, 32'd0, 1'b0, '0},
			'{ltsm_pkg::ACT_START, 63'd1, 32'd0, 1'b0, '0}
		};

		// Hold reset, then release it on a clock edge.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table at the reset target.
		for (int i = 0; i < NUM_DIRECTED; i++)
			send_event(directed_rows[i].act, directed_rows[i].stamp, directed_rows[i].dur,
				directed_rows[i].typed, directed_rows[i].want);

		// Random loop traffic under both target extremes and two ordinary ones.
		settle();
		write_target('0);
		loop_traffic(RANDOM_ITEMS);
		settle();
		write_target('1);
		loop_traffic(RANDOM_ITEMS);
		settle();
		odd_target = $urandom;
		write_target(odd_target);
		loop_traffic(RANDOM_ITEMS);
		settle();
		write_target(32'd1);
		loop_traffic(RANDOM_ITEMS);

		// Open a fresh window and run a stretch of loop ends through it.
		settle();
		write_target(ltsm_pkg::TARGET_RESET);
		send_event(ltsm_pkg::ACT_RESET, clock_us, $urandom, 1'b0, '0);
		for (int i = 0; i < FILL_ITEMS; i++) begin
			clock_us = clock_us + 63'($urandom_range(9000, 11000));
			send_event(ltsm_pkg::ACT_END, clock_us, pick_duration(), 1'b0, '0);
		end

		// Drain, then allow one transaction's worth of cycles for stray results.
		in_valid <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && pending_stats.size() == 0)
			$display("loop_timing_statistics_monitor_unit: match");
		else
			$display("loop_timing_statistics_monitor_unit: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
